>>> sv/assert_macros.svh
// Assertion macros shared by the dead reckoning RTL.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dr_pkg.sv
// Shared types, constants and helper functions for the dead reckoning block.
// Used by dr_cordic and encoder_imu_dead_reckoning; depends on nothing.
package dr_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_DISTANCE_PER_COUNT = 2'd0;
    localparam logic [1:0] REG_GLITCH_LIMIT       = 2'd1;
    localparam logic [15:0] GLITCH_LIMIT_RESET    = 16'd10000;

    // Angles are handled in 1/512 degree.
    localparam logic signed [19:0] TURN_UNITS         = 20'sd184320;
    localparam logic signed [19:0] HALF_TURN_UNITS    = 20'sd92160;
    localparam logic signed [19:0] QUARTER_TURN_UNITS = 20'sd46080;

    // Radians in Q30 = units * RAD_SCALE / 2^21, RAD_SCALE split in 32-bit halves.
    localparam logic [31:0] RAD_SCALE_LO = 32'd3745948243;
    localparam logic [31:0] RAD_SCALE_HI = 32'd17;
    localparam int          RAD_SHIFT    = 21;

    // CORDIC datapath.
    localparam int CW           = 34;
    localparam int TRIG_FRAC    = 30;
    localparam int QUAT_SHIFT   = 15;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);
    localparam logic [30:0] CORDIC_GAIN_Q30 = 31'd652032874;

    localparam logic [30:0] ATAN_Q30 [CORDIC_STEPS] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516,  31'd16775851,  31'd8388437,   31'd4194283,   31'd2097149,
        31'd1048576,   31'd524288,    31'd262144,    31'd131072,    31'd65536,
        31'd32768,     31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128,       31'd64,
        31'd32,        31'd16,        31'd8,         31'd4,         31'd2
    };

    // Angle folded into [-90, 90] degrees, as magnitude and sign.
    typedef struct packed {
        logic [15:0] m_abs;
        logic        m_neg;
        logic        fold_neg;
    } ang_red_t;

    // Reduces an angle modulo one turn into [-180, 180) degrees, then folds
    // the outer half circle onto the inner one and flags the sign flip.
    function automatic ang_red_t reduce_angle(logic signed [19:0] units);
        logic signed [19:0] v;
        ang_red_t r;
        v = units;
        if (v < 0)
            v = v + TURN_UNITS;
        if (v < 0)
            v = v + TURN_UNITS;
        if (v >= TURN_UNITS)
            v = v - TURN_UNITS;
        if (v >= HALF_TURN_UNITS)
            v = v - TURN_UNITS;
        r.fold_neg = 1'b0;
        if (v > QUARTER_TURN_UNITS)
        begin
            v = v - HALF_TURN_UNITS;
            r.fold_neg = 1'b1;
        end
        else if (v < -QUARTER_TURN_UNITS)
        begin
            v = v + HALF_TURN_UNITS;
            r.fold_neg = 1'b1;
        end
        r.m_neg = v[19];
        r.m_abs = v[19] ? 16'(-v) : 16'(v);
        return r;
    endfunction

endpackage

>>> sv/dr_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Stand-alone; the sequencer in the top level feeds its operands.
module dr_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'b0, a} * {32'b0, b};
    end

    assign prod = prod_reg;

endmodule

>>> sv/dr_cordic.sv
// Iterative rotation CORDIC, one micro-rotation per clock over 30 steps.
// Depends on dr_pkg for widths, gain and the arctangent table.
`include "assert_macros.svh"

module dr_cordic
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [dr_pkg::CW-1:0] z_init,
    output logic signed [dr_pkg::CW-1:0] cos_val,
    output logic signed [dr_pkg::CW-1:0] sin_val,
    output logic                       done
);
    import dr_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CORDIC_IW-1:0]  iter_reg;
    logic signed [CW-1:0]  x_reg;
    logic signed [CW-1:0]  y_reg;
    logic signed [CW-1:0]  z_reg;

    logic signed [CW-1:0]  xs;
    logic signed [CW-1:0]  ys;
    logic signed [CW-1:0]  at;
    logic                  last;

    assign xs   = x_reg >>> iter_reg;
    assign ys   = y_reg >>> iter_reg;
    assign at   = $signed(CW'(ATAN_Q30[iter_reg]));
    assign last = (iter_reg == CORDIC_IW'(CORDIC_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (last)
                    busy_reg <= 1'b0;
                else
                    iter_reg <= iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= $signed(CW'(CORDIC_GAIN_Q30));
            y_reg <= '0;
            z_reg <= z_init;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign cos_val = x_reg;
    assign sin_val = y_reg;
    assign done    = done_reg;

    `DR_ASSERT_NEXT(a_cordic_start, start, busy_reg && (iter_reg == '0), "CORDIC did not start")
    `DR_ASSERT_IMPL(a_cordic_done, done_reg, !busy_reg, "CORDIC done while still rotating")

endmodule

>>> sv/encoder_imu_dead_reckoning.sv
// Top level of the wheel-encoder and IMU dead reckoning block.
// Depends on dr_pkg, dr_mul and dr_cordic.
//
// Usage:
// The input channel carries one word per odometry update: the left and right
// absolute encoder counts and the IMU heading in 1/256 degree. A word is taken
// at a rising edge where item_valid is high and item_stall is low. The result
// channel returns one word per input word: the saturating x and y position in
// 2^-32 m and the yaw quaternion z and w terms in Q1.15, taken at a rising edge
// where result_valid is high and result_stall is low.
// The block takes no new word while an update is in progress. An update is
// made of two 30-step runs of the single CORDIC rotator (one at the heading
// for the position, one at half the heading for the quaternion) plus ten
// passes through the one shared 32x32 multiplier.
// The finished result sits in an output register, so the next input word can
// be accepted while it waits. If the receiver still stalls the previous word
// when a new result is ready, the sequencer holds in its last step until the
// output register frees up. Reset clears the position, the stored counts and
// the output valid flag, and sets distance_per_count to 0 and glitch_limit to
// 10000. The user must write registers through cfg_we, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this. An
// index beyond the list is ignored.
`include "assert_macros.svh"

module encoder_imu_dead_reckoning #(
    parameter int TRIG_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] left_count,
    input  logic signed [31:0] right_count,
    input  logic signed [17:0] heading,

    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [63:0] pos_x_out,
    output logic signed [63:0] pos_y_out,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w
);
    import dr_pkg::*;

    localparam int TW      = TRIG_BITS + 1;
    localparam int T_SHIFT = TRIG_FRAC - TRIG_BITS;
    localparam int RW      = 51 + TRIG_BITS;
    localparam logic signed [CW-1:0] T_HALF = CW'(64'd1 << (T_SHIFT - 1));
    localparam logic signed [CW-1:0] T_ONE  = CW'(64'd1 << TRIG_BITS);
    localparam logic signed [CW-1:0] Q_HALF = CW'(64'd1 << (QUAT_SHIFT - 1));
    localparam logic signed [CW-1:0] Q_MAX  = CW'(32767);
    localparam logic signed [CW-1:0] Q_MIN  = -CW'(32768);
    localparam logic [RW-1:0]        R_HALF = RW'(1) << TRIG_BITS;
    localparam logic signed [53:0]   Z_HALF = 54'sd1 <<< (RAD_SHIFT - 1);
    localparam logic signed [63:0]   POS_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0]   POS_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_MUL_L, S_MUL_R, S_SUM,
        S_ANG, S_ANG_LO, S_ANG_HI, S_ZSET, S_CSTART, S_CRUN,
        S_TRIG0, S_R_LO, S_R_HI, S_R_SUM, S_R_UPD, S_QUAT, S_DONE
    } state_t;

    // Rounds a Q30 value to Q(TRIG_BITS), clamps to one and splits off the sign.
    function automatic logic [TW:0] to_trig(logic signed [CW-1:0] v);
        logic signed [CW-1:0] rv;
        logic                 neg;
        logic [TW-1:0]        mag;
        rv = (v + T_HALF) >>> T_SHIFT;
        if (rv > T_ONE)
            rv = T_ONE;
        else if (rv < -T_ONE)
            rv = -T_ONE;
        neg = rv[CW-1];
        mag = neg ? TW'(-rv) : TW'(rv);
        return {neg, mag};
    endfunction

    // Rounds a Q30 value to Q15 and clamps it to the 16-bit range.
    function automatic logic signed [15:0] to_quat(logic signed [CW-1:0] v);
        logic signed [CW-1:0] rv;
        rv = (v + Q_HALF) >>> QUAT_SHIFT;
        if (rv > Q_MAX)
            rv = Q_MAX;
        else if (rv < Q_MIN)
            rv = Q_MIN;
        return 16'(rv);
    endfunction

    // Control and state registers.
    state_t              state_reg;
    logic                pass_reg;
    logic                axis_reg;
    logic                result_valid_reg;
    logic [31:0]         dpc_reg;
    logic [15:0]         glitch_reg;
    logic [31:0]         prev_left_reg;
    logic [31:0]         prev_right_reg;
    logic signed [63:0]  acc_x_reg;
    logic signed [63:0]  acc_y_reg;

    // Datapath registers.
    logic [31:0]         left_reg;
    logic [31:0]         right_reg;
    logic signed [17:0]  heading_reg;
    logic [15:0]         mag_l_reg;
    logic [15:0]         mag_r_reg;
    logic                neg_l_reg;
    logic                neg_r_reg;
    logic signed [48:0]  dist_l_reg;
    logic signed [49:0]  sum_reg;
    logic [48:0]         su_reg;
    logic                sum_neg_reg;
    ang_red_t            ang_reg;
    logic [52:0]         zacc_reg;
    logic signed [CW-1:0] c_reg;
    logic signed [CW-1:0] s_reg;
    logic [TW-1:0]       ct_abs_reg;
    logic [TW-1:0]       st_abs_reg;
    logic                ct_neg_reg;
    logic                st_neg_reg;
    logic [63:0]         rlo_reg;
    logic [RW-1:0]       rfull_reg;
    logic signed [15:0]  qz_reg;
    logic signed [15:0]  qw_reg;
    logic signed [63:0]  pos_x_reg;
    logic signed [63:0]  pos_y_reg;
    logic signed [15:0]  quat_z_reg;
    logic signed [15:0]  quat_w_reg;

    // Combinational signals.
    logic                accept;
    logic                out_free;
    logic [31:0]         d_l;
    logic [31:0]         dn_l;
    logic [31:0]         magw_l;
    logic                keep_l;
    logic [31:0]         d_r;
    logic [31:0]         dn_r;
    logic [31:0]         magw_r;
    logic                keep_r;
    logic signed [48:0]  dist_l_next;
    logic signed [48:0]  dist_r;
    logic signed [49:0]  sum_next;
    logic signed [19:0]  units;
    logic signed [53:0]  z_signed;
    logic signed [53:0]  z_round;
    logic signed [CW-1:0] z_init;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         prod;
    logic [TW-1:0]       t_abs;
    logic                r_neg;
    logic [63:0]         r_mag;
    logic signed [63:0]  acc_sel;
    logic signed [64:0]  acc_wide;
    logic signed [63:0]  acc_next;
    logic                cordic_start;
    logic                cordic_done;
    logic signed [CW-1:0] cordic_cos;
    logic signed [CW-1:0] cordic_sin;
    logic signed [CW-1:0] c_fold;
    logic signed [CW-1:0] s_fold;
    logic [TW:0]         ct_pack;
    logic [TW:0]         st_pack;

    assign accept   = item_valid && !item_stall;
    assign out_free = !result_valid_reg || !result_stall;

    // Wheel count differences: both subtraction orders are formed so that the
    // magnitude is a plain select. A zero or glitching difference turns into
    // a zero magnitude, which makes that wheel contribute nothing.
    assign d_l    = left_reg - prev_left_reg;
    assign dn_l   = prev_left_reg - left_reg;
    assign magw_l = d_l[31] ? dn_l : d_l;
    assign keep_l = (magw_l != 32'd0) && (magw_l < {16'b0, glitch_reg});
    assign d_r    = right_reg - prev_right_reg;
    assign dn_r   = prev_right_reg - right_reg;
    assign magw_r = d_r[31] ? dn_r : d_r;
    assign keep_r = (magw_r != 32'd0) && (magw_r < {16'b0, glitch_reg});

    // Signed wheel distances from the multiplier output.
    assign dist_l_next = neg_l_reg ? -$signed({1'b0, prod[47:0]}) : $signed({1'b0, prod[47:0]});
    assign dist_r      = neg_r_reg ? -$signed({1'b0, prod[47:0]}) : $signed({1'b0, prod[47:0]});
    assign sum_next    = 50'(dist_l_reg) + 50'(dist_r);

    // The first trig pass rotates by the heading in 1/512 degree units
    // (twice the 1/256 degree input), the second uses the heading itself,
    // which yields the half angle needed by the quaternion.
    assign units = pass_reg ? 20'(heading_reg) : 20'($signed({heading_reg, 1'b0}));

    // Starting angle in Q30 radians, rounded half up.
    assign z_signed = ang_reg.m_neg ? -$signed({1'b0, zacc_reg}) : $signed({1'b0, zacc_reg});
    assign z_round  = z_signed + Z_HALF;
    assign z_init   = CW'(z_round >>> RAD_SHIFT);

    assign t_abs = axis_reg ? st_abs_reg : ct_abs_reg;

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_L:
            begin
                mul_a = {16'b0, mag_l_reg};
                mul_b = dpc_reg;
            end
            S_MUL_R:
            begin
                mul_a = {16'b0, mag_r_reg};
                mul_b = dpc_reg;
            end
            S_ANG_LO:
            begin
                mul_a = {16'b0, ang_reg.m_abs};
                mul_b = RAD_SCALE_LO;
            end
            S_ANG_HI:
            begin
                mul_a = {16'b0, ang_reg.m_abs};
                mul_b = RAD_SCALE_HI;
            end
            S_R_LO:
            begin
                mul_a = su_reg[31:0];
                mul_b = 32'(t_abs);
            end
            S_R_HI:
            begin
                mul_a = 32'(su_reg[48:32]);
                mul_b = 32'(t_abs);
            end
            default:
            begin
            end
        endcase
    end

    dr_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cordic_start = (state_reg == S_CSTART);

    dr_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .z_init  (z_init),
        .cos_val (cordic_cos),
        .sin_val (cordic_sin),
        .done    (cordic_done)
    );

    // Undo the half-circle fold on the CORDIC result.
    assign c_fold = ang_reg.fold_neg ? -cordic_cos : cordic_cos;
    assign s_fold = ang_reg.fold_neg ? -cordic_sin : cordic_sin;

    assign ct_pack = to_trig(c_reg);
    assign st_pack = to_trig(s_reg);

    // Position update: the rounded product magnitude is added or subtracted
    // with one spare bit, and a sign mismatch in the top two bits saturates.
    assign r_neg    = sum_neg_reg ^ (axis_reg ? st_neg_reg : ct_neg_reg);
    assign r_mag    = 64'(rfull_reg >> (TRIG_BITS + 1));
    assign acc_sel  = axis_reg ? acc_y_reg : acc_x_reg;
    assign acc_wide = r_neg ? ({acc_sel[63], acc_sel} - $signed({1'b0, r_mag}))
                            : ({acc_sel[63], acc_sel} + $signed({1'b0, r_mag}));
    assign acc_next = (acc_wide[64] != acc_wide[63]) ? (acc_wide[64] ? POS_MIN : POS_MAX)
                                                     : acc_wide[63:0];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpc_reg    <= '0;
            glitch_reg <= GLITCH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DISTANCE_PER_COUNT: dpc_reg <= cfg_data;
                REG_GLITCH_LIMIT:       glitch_reg <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer with the block state it owns.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pass_reg         <= 1'b0;
            axis_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            prev_left_reg    <= '0;
            prev_right_reg   <= '0;
            acc_x_reg        <= '0;
            acc_y_reg        <= '0;
        end
        else
        begin
            // A new result word takes over the output register in the same
            // cycle that the previous one leaves.
            if (state_reg == S_DONE && out_free)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pass_reg  <= 1'b0;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:   state_reg <= S_MUL_L;
                S_MUL_L:  state_reg <= S_MUL_R;
                S_MUL_R:  state_reg <= S_SUM;
                S_SUM:    state_reg <= S_ANG;
                S_ANG:    state_reg <= S_ANG_LO;
                S_ANG_LO: state_reg <= S_ANG_HI;
                S_ANG_HI: state_reg <= S_ZSET;
                S_ZSET:   state_reg <= S_CSTART;
                S_CSTART: state_reg <= S_CRUN;
                S_CRUN:
                begin
                    if (cordic_done)
                        state_reg <= pass_reg ? S_QUAT : S_TRIG0;
                end
                S_TRIG0:
                begin
                    axis_reg  <= 1'b0;
                    state_reg <= S_R_LO;
                end
                S_R_LO:   state_reg <= S_R_HI;
                S_R_HI:   state_reg <= S_R_SUM;
                S_R_SUM:  state_reg <= S_R_UPD;
                S_R_UPD:
                begin
                    if (axis_reg)
                    begin
                        acc_y_reg <= acc_next;
                        pass_reg  <= 1'b1;
                        state_reg <= S_ANG;
                    end
                    else
                    begin
                        acc_x_reg <= acc_next;
                        axis_reg  <= 1'b1;
                        state_reg <= S_R_LO;
                    end
                end
                S_QUAT:   state_reg <= S_DONE;
                S_DONE:
                begin
                    if (out_free)
                    begin
                        prev_left_reg    <= left_reg;
                        prev_right_reg   <= right_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers, loaded as the sequencer walks through its steps.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    left_reg    <= left_count;
                    right_reg   <= right_count;
                    heading_reg <= heading;
                end
            end
            S_DIFF:
            begin
                mag_l_reg <= keep_l ? magw_l[15:0] : 16'd0;
                mag_r_reg <= keep_r ? magw_r[15:0] : 16'd0;
                neg_l_reg <= d_l[31];
                neg_r_reg <= d_r[31];
            end
            S_MUL_R:  dist_l_reg <= dist_l_next;
            S_SUM:    sum_reg <= sum_next;
            S_ANG:
            begin
                ang_reg     <= reduce_angle(units);
                sum_neg_reg <= sum_reg[49];
                su_reg      <= sum_reg[49] ? 49'(-sum_reg) : 49'(sum_reg);
            end
            S_ANG_HI: zacc_reg <= 53'(prod[47:0]);
            S_ZSET:   zacc_reg <= zacc_reg + {prod[20:0], 32'b0};
            S_CRUN:
            begin
                if (cordic_done)
                begin
                    c_reg <= c_fold;
                    s_reg <= s_fold;
                end
            end
            S_TRIG0:
            begin
                ct_neg_reg <= ct_pack[TW];
                ct_abs_reg <= ct_pack[TW-1:0];
                st_neg_reg <= st_pack[TW];
                st_abs_reg <= st_pack[TW-1:0];
            end
            S_R_HI:   rlo_reg <= prod;
            S_R_SUM:  rfull_reg <= RW'(rlo_reg) + (RW'(prod) << 32) + R_HALF;
            S_QUAT:
            begin
                qw_reg <= to_quat(c_reg);
                qz_reg <= to_quat(s_reg);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    pos_x_reg  <= acc_x_reg;
                    pos_y_reg  <= acc_y_reg;
                    quat_z_reg <= qz_reg;
                    quat_w_reg <= qw_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign pos_x_out    = pos_x_reg;
    assign pos_y_out    = pos_y_reg;
    assign quat_z       = quat_z_reg;
    assign quat_w       = quat_w_reg;

    `DR_ASSERT_NEXT(a_busy_after_accept, accept, item_stall, "input not stalled after accept")
    `DR_ASSERT_IMPL(a_result_from_done, $rose(result_valid), $past(state_reg == S_DONE), "result word without a finished update")
    `DR_ASSERT_NEXT(a_acc_hold, state_reg != S_R_UPD, $stable(acc_x_reg) && $stable(acc_y_reg), "position changed outside its update step")

endmodule
